FILE: hdl/tpcf_pkg.sv
package tpcf_pkg;

    // Field widths.
    localparam int RAW_W      = 12;
    localparam int MULT_W     = 11;
    localparam int PROD_W     = RAW_W + MULT_W;
    localparam int OFF_W      = 13;
    localparam int DIV_W      = 13;
    localparam int RES_W      = 12;
    localparam int COORD_W    = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Smoothing strength of the first-order filter.
    localparam int FILTER_SHIFT = 2;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Largest resolution that the clamp honors.
    localparam logic [RES_W-1:0] MAX_RES = RES_W'(2048);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_MULT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_DIV    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_MULT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_DIV    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_HOR_RES  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_VER_RES  = 3'd7;

    typedef struct packed {
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
        logic             pressed;
    } t_sample;

    typedef struct packed {
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
        logic               touch_state;
    } t_result;

    typedef struct packed {
        logic signed [OFF_W-1:0] x_offset;
        logic [MULT_W-1:0]       x_mult;
        logic signed [DIV_W-1:0] x_div;
        logic signed [OFF_W-1:0] y_offset;
        logic [MULT_W-1:0]       y_mult;
        logic signed [DIV_W-1:0] y_div;
        logic [RES_W-1:0]        hor_res;
        logic [RES_W-1:0]        ver_res;
    } t_cfg;

    // What the back has to do with a sample.
    typedef enum logic [1:0] {
        KIND_RELEASE,
        KIND_SEED,
        KIND_TRACK
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [PROD_W-1:0] prod_x;
        logic [PROD_W-1:0] prod_y;
    } t_job;

endpackage

FILE: hdl/tpcf_front.sv
module tpcf_front
    import tpcf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_push,
    input  logic    i_full,
    input  t_sample i_sample,
    output logic    o_push,
    output t_job    o_job
);

    logic r_was_pressed;
    logic n_was_pressed;

    assign o_push = i_push && !i_full;

    always_comb begin
        o_job.prod_x = PROD_W'(i_sample.raw_x) * PROD_W'(i_cfg.x_mult);
        o_job.prod_y = PROD_W'(i_sample.raw_y) * PROD_W'(i_cfg.y_mult);
        if (!i_sample.pressed) begin
            o_job.kind = KIND_RELEASE;
        end else if (!r_was_pressed) begin
            o_job.kind = KIND_SEED;
        end else begin
            o_job.kind = KIND_TRACK;
        end
        n_was_pressed = o_push ? i_sample.pressed : r_was_pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_was_pressed <= 1'b0;
        end else begin
            r_was_pressed <= n_was_pressed;
        end
    end

endmodule

FILE: hdl/tpcf_queue.sv
module tpcf_queue
    import tpcf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= next_ptr(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= next_ptr(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue popped while empty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue pushed while full");
`endif

endmodule

FILE: hdl/tpcf_div.sv
module tpcf_div
    import tpcf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0]  i_divisor,
    output logic              o_busy,
    output logic [PROD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [CNT_W-1:0]  r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_quo;
    logic [DIV_W-1:0]  r_divisor;

    logic [DIV_W:0]    trial;
    logic              ge;
    logic [DIV_W-1:0]  n_rem;
    logic [PROD_W-1:0] n_quo;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        trial = {r_rem, r_quo[PROD_W-1]};
        ge    = (trial >= {1'b0, r_divisor});
        n_rem = ge ? DIV_W'(trial - {1'b0, r_divisor}) : DIV_W'(trial);
        n_quo = {r_quo[PROD_W-2:0], ge};
    end

    assign o_busy     = (r_cnt != '0);
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(PROD_W);
        end else if (o_busy) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= '0;
            r_quo     <= i_dividend;
            r_divisor <= i_divisor;
        end else if (o_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PROD_W))
        else $error("divider step count out of range");
`endif

endmodule

FILE: hdl/tpcf_back.sv
module tpcf_back
    import tpcf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_out
);

    localparam int V_W = PROD_W + 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MAP,
        ST_WRITE
    } t_state;

    t_state             r_state;
    t_kind              r_kind;
    logic [COORD_W-1:0] r_px;
    logic [COORD_W-1:0] r_py;
    logic [COORD_W-1:0] r_filt_x;
    logic [COORD_W-1:0] r_filt_y;
    logic               r_out_valid;
    t_result            r_out;

    logic               div_start;
    logic               x_busy;
    logic               y_busy;
    logic [PROD_W-1:0]  x_quo;
    logic [PROD_W-1:0]  y_quo;
    logic [DIV_W-1:0]   x_mag;
    logic [DIV_W-1:0]   y_mag;
    logic               out_free;
    logic [COORD_W-1:0] n_filt_x;
    logic [COORD_W-1:0] n_filt_y;

    // Offset plus signed quotient, then clamp to 0 .. min(resolution, MAX_RES)-1.
    function automatic logic [COORD_W-1:0] map_axis(
        input logic [PROD_W-1:0]       q,
        input logic signed [OFF_W-1:0] off,
        input logic signed [DIV_W-1:0] dv,
        input logic [RES_W-1:0]        res
    );
        logic signed [V_W-1:0] qs;
        logic signed [V_W-1:0] v;
        logic [RES_W-1:0]      res_eff;
        logic [COORD_W-1:0]    lim;
        qs = signed'({2'b00, q});
        if (dv[DIV_W-1]) begin
            qs = -qs;
        end
        if (dv == '0) begin
            qs = '0;
        end
        v       = V_W'(off) + qs;
        res_eff = (res > MAX_RES) ? MAX_RES : res;
        lim     = COORD_W'(res_eff - 1'b1);
        if (res == '0 || v < 0) begin
            return '0;
        end else if (v > signed'({{(V_W - COORD_W){1'b0}}, lim})) begin
            return lim;
        end else begin
            return v[COORD_W-1:0];
        end
    endfunction

    function automatic logic [COORD_W-1:0] iir(
        input logic [COORD_W-1:0] p,
        input logic [COORD_W-1:0] prev
    );
        return (p >> FILTER_SHIFT) + prev - (prev >> FILTER_SHIFT);
    endfunction

    assign x_mag = i_cfg.x_div[DIV_W-1] ? DIV_W'(-i_cfg.x_div) : DIV_W'(i_cfg.x_div);
    assign y_mag = i_cfg.y_div[DIV_W-1] ? DIV_W'(-i_cfg.y_div) : DIV_W'(i_cfg.y_div);

    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;
    assign div_start = o_job_pop && (i_job.kind != KIND_RELEASE);
    assign out_free  = !r_out_valid || i_pop;
    assign o_empty   = !r_out_valid;
    assign o_out     = r_out;

    tpcf_div u_div_x (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_job.prod_x),
        .i_divisor  (x_mag),
        .o_busy     (x_busy),
        .o_quotient (x_quo)
    );

    tpcf_div u_div_y (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_job.prod_y),
        .i_divisor  (y_mag),
        .o_busy     (y_busy),
        .o_quotient (y_quo)
    );

    always_comb begin
        if (r_kind == KIND_SEED) begin
            n_filt_x = iir(r_px, r_px);
            n_filt_y = iir(r_py, r_py);
        end else begin
            n_filt_x = iir(r_px, r_filt_x);
            n_filt_y = iir(r_py, r_filt_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_filt_x    <= '0;
            r_filt_y    <= '0;
        end else begin
            // In the write step a popped result is replaced by the new one.
            if (i_pop && r_out_valid && r_state != ST_WRITE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_job_pop) begin
                        r_kind  <= i_job.kind;
                        r_state <= (i_job.kind == KIND_RELEASE) ? ST_WRITE : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (!x_busy) begin
                        r_state <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    r_px    <= map_axis(x_quo, i_cfg.x_offset, i_cfg.x_div, i_cfg.hor_res);
                    r_py    <= map_axis(y_quo, i_cfg.y_offset, i_cfg.y_div, i_cfg.ver_res);
                    r_state <= ST_WRITE;
                end
                ST_WRITE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_kind == KIND_RELEASE) begin
                            r_out.screen_x    <= r_filt_x;
                            r_out.screen_y    <= r_filt_y;
                            r_out.touch_state <= 1'b0;
                        end else begin
                            r_filt_x          <= n_filt_x;
                            r_filt_y          <= n_filt_y;
                            r_out.screen_x    <= n_filt_x;
                            r_out.screen_y    <= n_filt_y;
                            r_out.touch_state <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        x_busy == y_busy)
        else $error("axis dividers out of step");
    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("result not loaded after write");
`endif

endmodule

FILE: hdl/touch_point_calibrate_filter.sv
// Touch point calibration and smoothing.
// Input channel: a request carries one raw sample (raw_x, raw_y, pressed) on
// i_in; it is taken at a clock edge where push is high and full is low.
// Result channel: while empty is low, o_out holds the oldest result (screen_x,
// screen_y, touch_state); it is taken at an edge where pop is high.
// Every request gives exactly one result, in order.
// Processing: a pressed sample goes through the queue pop, the two 23-step
// restoring dividers (one per axis, run side by side), divider finish,
// mapping and write steps. A released sample goes from the queue pop straight
// to the write step. The back finishes one sample at a time and takes no new
// sample until it is through with the last; a two-entry queue lets the front
// keep taking requests while the back works.
// Configuration written through i_cfg_we, i_cfg_idx and i_cfg_data takes effect
// at once. Write it only while idle; the block itself does not enforce this.
// Reset (synchronous, i_rst_n low) empties the queue and result register,
// zeroes the filtered point, marks the panel released and restores the
// calibration registers to their defaults.
// When the receiver stalls, the finished result waits in the output register,
// the back stops in its write step and the queue fills until full rises.
module touch_point_calibrate_filter
    import tpcf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_sample               i_in,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Calibration register file, shared by the front (scale numerators) and
    // the back (offsets, divisors and clamp limits).
    t_cfg r_cfg;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_job front_job;
    t_job back_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_offset <= '0;
            r_cfg.x_mult   <= MULT_W'(1);
            r_cfg.x_div    <= DIV_W'(1);
            r_cfg.y_offset <= '0;
            r_cfg.y_mult   <= MULT_W'(1);
            r_cfg.y_div    <= DIV_W'(1);
            r_cfg.hor_res  <= RES_W'(800);
            r_cfg.ver_res  <= RES_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_X_OFFSET: r_cfg.x_offset <= OFF_W'(i_cfg_data);
                CFG_X_MULT:   r_cfg.x_mult   <= i_cfg_data[MULT_W-1:0];
                CFG_X_DIV:    r_cfg.x_div    <= DIV_W'(i_cfg_data);
                CFG_Y_OFFSET: r_cfg.y_offset <= OFF_W'(i_cfg_data);
                CFG_Y_MULT:   r_cfg.y_mult   <= i_cfg_data[MULT_W-1:0];
                CFG_Y_DIV:    r_cfg.y_div    <= DIV_W'(i_cfg_data);
                CFG_HOR_RES:  r_cfg.hor_res  <= i_cfg_data[RES_W-1:0];
                CFG_VER_RES:  r_cfg.ver_res  <= i_cfg_data[RES_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front classifies each sample as release, press edge or held press
    // and forms the raw-times-numerator products.
    tpcf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_full   (q_full),
        .i_sample (i_in),
        .o_push   (q_push),
        .o_job    (front_job)
    );

    tpcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (back_job)
    );

    // The back divides, maps, clamps, filters and holds the result.
    tpcf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (!q_empty),
        .i_job       (back_job),
        .o_job_pop   (q_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out       (o_out)
    );

    assign full = q_full;

endmodule
